@@ hw/rtl/fspa_pkg.sv @@
`timescale 1ns / 1ps

package fspa_pkg;

   localparam int SLOTS_DEFAULT     = 16;
   localparam int ADDR_BITS_DEFAULT = 32;
   localparam int SIZE_BITS_DEFAULT = 24;

   localparam int COUNT_W   = 5;
   localparam int TYPE_W    = 2;
   localparam int SLOTNUM_W = 4;
   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 24;
   localparam int STATUS_W  = 3;

   localparam logic [TYPE_W-1:0] REQ_LOAD    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_LOADED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_OOM       = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_UNMATCHED = 3'd4;

   typedef struct packed {
      logic [TYPE_W-1:0]    req_type;
      logic [SLOTNUM_W-1:0] slot_number;
      logic [ADDR_W-1:0]    req_addr;
      logic [SIZE_W-1:0]    req_size;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ADDR_W-1:0]    grant_addr;
      logic [SLOTNUM_W-1:0] slot_hit;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_REJECT
   } state_type;

   typedef struct packed {
      logic latch;
      logic load_wr;
      logic step;
      logic hit;
      logic fail;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic match;
      logic last;
   } stat_type;

endpackage

@@ hw/rtl/fixed_slot_pool_allocator_top.sv @@
`timescale 1ns / 1ps
// Load and unused request types: busy is high for one cycle, the result strobe follows it.
// Allocate and release scan one slot per cycle from slot 0 and stop at the first match or at
// the last active slot; a request that finds no active slot fails without a scan.
// The next request is taken in the strobe cycle.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Synchronous reset frees every slot and clears the slot count; slot contents are not cleared.

module fixed_slot_pool_allocator_top #(
   parameter int SLOTS     = fspa_pkg::SLOTS_DEFAULT,
   parameter int ADDR_BITS = fspa_pkg::ADDR_BITS_DEFAULT,
   parameter int SIZE_BITS = fspa_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  fspa_pkg::req_item_type        req_data,
   output logic                          rsp_valid,
   output fspa_pkg::rsp_item_type        rsp_data,
   input  logic                          csr_wr_en,
   input  logic [fspa_pkg::COUNT_W-1:0]  csr_wr_data
);
   import fspa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   fspa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   fspa_datapath #(
      .SLOTS     (SLOTS),
      .ADDR_BITS (ADDR_BITS),
      .SIZE_BITS (SIZE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

@@ hw/rtl/fspa_ctrl.sv @@
`timescale 1ns / 1ps

module fspa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fspa_pkg::TYPE_W-1:0]   req_type,
   input  fspa_pkg::stat_type            stat,
   output logic                          busy,
   output fspa_pkg::cmd_type             cmd
);
   import fspa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_LOAD:    state_in = ST_LOAD;
                  REQ_ALLOC:   state_in = ST_SCAN;
                  REQ_RELEASE: state_in = ST_SCAN;
                  default:     state_in = ST_REJECT;
               endcase
            end
         end
         ST_LOAD:   state_in = ST_IDLE;
         ST_SCAN: begin
            if (stat.empty || stat.match || stat.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_REJECT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
         end
         ST_SCAN: begin
            if (stat.empty) begin
               cmd.fail = 1'b1;
            end else if (stat.match) begin
               cmd.hit = 1'b1;
            end else if (stat.last) begin
               cmd.fail = 1'b1;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_REJECT: begin
            cmd.fail = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_hit_fail_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.hit && cmd.fail))
      else $error("hit and fail issued together");

endmodule

@@ hw/rtl/fspa_datapath.sv @@
`timescale 1ns / 1ps

module fspa_datapath #(
   parameter int SLOTS     = fspa_pkg::SLOTS_DEFAULT,
   parameter int ADDR_BITS = fspa_pkg::ADDR_BITS_DEFAULT,
   parameter int SIZE_BITS = fspa_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fspa_pkg::req_item_type           req_data,
   input  logic                             csr_wr_en,
   input  logic [fspa_pkg::COUNT_W-1:0]     csr_wr_data,
   input  fspa_pkg::cmd_type                cmd,
   output fspa_pkg::stat_type               stat,
   output logic                             rsp_valid,
   output fspa_pkg::rsp_item_type           rsp_data
);
   import fspa_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   logic [ADDR_BITS-1:0] base_mem [SLOTS];
   logic [SIZE_BITS-1:0] bytes_mem [SLOTS];

   req_item_type         req_ff;
   logic [COUNT_W-1:0]   slot_count_ff;
   logic [SLOTS-1:0]     busy_ff;
   logic [SLOTS-1:0]     busy_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_in;
   logic [ADDR_BITS-1:0] rd_base_ff;
   logic [SIZE_BITS-1:0] rd_bytes_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_item_type         rsp_ff;
   rsp_item_type         rsp_in;

   logic [CNT_W-1:0]     active_n;
   logic                 is_alloc;
   logic                 load_in_range;
   logic [IDX_W-1:0]     load_idx;
   logic [ADDR_BITS-1:0] key_addr;
   logic [SIZE_BITS-1:0] key_size;

   always_comb begin
      if (int'(slot_count_ff) > SLOTS) begin
         active_n = CNT_W'(SLOTS);
      end else begin
         active_n = CNT_W'(slot_count_ff);
      end
   end

   assign is_alloc      = (req_ff.req_type == REQ_ALLOC);
   assign load_in_range = (int'(req_ff.slot_number) < SLOTS);
   assign load_idx      = IDX_W'(req_ff.slot_number);
   assign key_addr      = ADDR_BITS'(req_ff.req_addr);
   assign key_size      = SIZE_BITS'(req_ff.req_size);

   always_comb begin
      stat.empty = (active_n == '0);
      stat.last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == active_n);
      if (is_alloc) begin
         stat.match = !busy_ff[idx_ff] && (rd_bytes_ff == key_size);
      end else begin
         stat.match = busy_ff[idx_ff] && (rd_base_ff == key_addr);
      end
   end

   always_comb begin
      if (cmd.latch) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (cmd.load_wr && load_in_range) begin
         busy_in[load_idx] = 1'b0;
      end
      if (cmd.hit) begin
         busy_in[idx_ff] = is_alloc;
      end
   end

   always_comb begin
      rsp_valid_in = cmd.load_wr || cmd.hit || cmd.fail;
      rsp_in       = '0;
      if (cmd.load_wr) begin
         rsp_in.status   = STATUS_LOADED;
         rsp_in.slot_hit = req_ff.slot_number;
      end else if (cmd.hit) begin
         rsp_in.slot_hit = SLOTNUM_W'(idx_ff);
         if (is_alloc) begin
            rsp_in.status     = STATUS_GRANTED;
            rsp_in.grant_addr = ADDR_W'(rd_base_ff);
         end else begin
            rsp_in.status = STATUS_RELEASED;
         end
      end else begin
         rsp_in.status = is_alloc ? STATUS_OOM : STATUS_UNMATCHED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= '0;
         busy_ff       <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slot_count_ff <= csr_wr_data;
         end
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_in_range) begin
         base_mem[load_idx]  <= key_addr;
         bytes_mem[load_idx] <= key_size;
      end
      rd_base_ff  <= base_mem[idx_in];
      rd_bytes_ff <= bytes_mem[idx_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_grant_marks_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.hit && is_alloc |=> busy_ff[$past(idx_ff)])
      else $error("granted slot not marked busy");

   a_release_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.hit && !is_alloc |=> !busy_ff[$past(idx_ff)])
      else $error("released slot still busy");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_GRANTED) |-> (rsp_data.grant_addr == '0))
      else $error("address reported without a grant");

endmodule
